@@ rtl/hbcc_pkg.sv @@
// Shared types, constants and the box match function for the hue box color classifier.
`default_nettype none

package hbcc_pkg;

  // Table size and the width of an index into the table.
  localparam int MaxColors = 8;
  localparam int TabIdxW   = (MaxColors > 1) ? $clog2(MaxColors) : 1;

  // Depth of the command queue between the front and the back.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  // Operation codes of an input item.
  localparam logic OpClassify = 1'b0;
  localparam logic OpWrite    = 1'b1;

  // Configuration register word index and reset value.
  localparam logic RegColorsInUse = 1'b0;
  localparam logic [3:0] ColorsInUseRst = 4'd0;

  typedef struct packed {
    logic       operation;
    logic [2:0] entry_index;
    logic [8:0] hue;
    logic [6:0] second_level;
    logic [6:0] third_level;
    logic [8:0] hue_low;
    logic [8:0] hue_high;
    logic [6:0] second_low;
    logic [6:0] second_high;
    logic [6:0] third_low;
    logic [6:0] third_high;
  } in_item_t;

  typedef struct packed {
    logic       color_found;
    logic [2:0] color_index;
  } out_item_t;

  typedef struct packed {
    logic [8:0] hue;
    logic [6:0] second_level;
    logic [6:0] third_level;
  } pixel_t;

  typedef struct packed {
    logic [8:0] hue_low;
    logic [8:0] hue_high;
    logic [6:0] second_low;
    logic [6:0] second_high;
    logic [6:0] third_low;
    logic [6:0] third_high;
  } box_t;

  // Decoded command handed from the front to the back.
  typedef struct packed {
    logic       is_write;
    logic       wr_en;
    logic [2:0] idx;
    pixel_t     pix;
    box_t       box;
  } cmd_t;

  // Queue status seen by the back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // A low hue bound above the high bound means the hue range wraps past zero.
  function automatic logic box_holds(input box_t b, input pixel_t p);
    logic hue_ok;
    hue_ok = (b.hue_low <= b.hue_high) ?
             ((p.hue >= b.hue_low) && (p.hue <= b.hue_high)) :
             ((p.hue >= b.hue_low) || (p.hue <= b.hue_high));
    return hue_ok &&
           (p.second_level >= b.second_low) && (p.second_level <= b.second_high) &&
           (p.third_level >= b.third_low) && (p.third_level <= b.third_high);
  endfunction

endpackage

`default_nettype wire

@@ rtl/hbcc_front.sv @@
// Front end: accepts input transfers and decodes them into queue commands.
`default_nettype none

module hbcc_front (
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire hbcc_pkg::in_item_t in_data,
  input  wire logic              q_full,
  output logic                   push,
  output hbcc_pkg::cmd_t         push_cmd
);

  always_comb begin
    in_stall = q_full;
    push     = in_valid && !q_full;

    push_cmd.is_write = (in_data.operation == hbcc_pkg::OpWrite);
    // Writes beyond the table are flagged here; the back does not store them.
    push_cmd.wr_en    = (int'(in_data.entry_index) < hbcc_pkg::MaxColors);
    push_cmd.idx      = in_data.entry_index;

    push_cmd.pix.hue          = in_data.hue;
    push_cmd.pix.second_level = in_data.second_level;
    push_cmd.pix.third_level  = in_data.third_level;

    push_cmd.box.hue_low     = in_data.hue_low;
    push_cmd.box.hue_high    = in_data.hue_high;
    push_cmd.box.second_low  = in_data.second_low;
    push_cmd.box.second_high = in_data.second_high;
    push_cmd.box.third_low   = in_data.third_low;
    push_cmd.box.third_high  = in_data.third_high;
  end

endmodule

`default_nettype wire

@@ rtl/hbcc_queue.sv @@
// Short command queue that decouples the front from the back.
`default_nettype none

module hbcc_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire hbcc_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output hbcc_pkg::cmd_t      head_cmd,
  output hbcc_pkg::q_stat_t   stat
);

  hbcc_pkg::cmd_t mem_r [hbcc_pkg::QDepth];

  logic [hbcc_pkg::QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [hbcc_pkg::QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [hbcc_pkg::QPtrW:0]   count_r, count_nxt;

  always_comb begin
    stat.full  = (count_r == (hbcc_pkg::QPtrW+1)'(hbcc_pkg::QDepth));
    stat.empty = (count_r == '0);
    head_cmd   = mem_r[rd_ptr_r];

    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

@@ rtl/hbcc_back.sv @@
// Back end: holds the color table, runs writes and classifications, drives the result.
`default_nettype none

module hbcc_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [3:0]        colors_in_use,
  input  wire hbcc_pkg::cmd_t    head_cmd,
  input  wire hbcc_pkg::q_stat_t stat,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output hbcc_pkg::out_item_t    out_data
);

  hbcc_pkg::box_t table_r [hbcc_pkg::MaxColors];

  logic                out_valid_r, out_valid_nxt;
  hbcc_pkg::out_item_t out_data_r, out_data_nxt;
  hbcc_pkg::out_item_t match;
  logic                do_class;

  // All entries are compared at once; the lowest in-use match wins.
  always_comb begin
    match = '0;
    for (int k = hbcc_pkg::MaxColors - 1; k >= 0; k--) begin
      if ((k < int'(colors_in_use)) && hbcc_pkg::box_holds(table_r[k], head_cmd.pix)) begin
        match.color_found = 1'b1;
        match.color_index = 3'(k);
      end
    end
  end

  always_comb begin
    // A write never waits on the output side; a classification needs a free result slot.
    pop      = !stat.empty && (head_cmd.is_write || !out_valid_r || !out_stall);
    do_class = pop && !head_cmd.is_write;

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (do_class) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = match;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    out_valid = out_valid_r;
    out_data  = out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (pop && head_cmd.is_write && head_cmd.wr_en) begin
      table_r[hbcc_pkg::TabIdxW'(head_cmd.idx)] <= head_cmd.box;
    end
  end

endmodule

`default_nettype wire

@@ rtl/hue_box_color_classifier.sv @@
// Top level of the hue box color classifier: configuration register and front/back wiring.
//
// Input items arrive on in_valid/in_stall/in_data. An item either writes one
// entry of the color table or classifies one pixel against the table. Each
// classify item yields exactly one result on out_valid/out_stall/out_data;
// a write item yields none. Items are handled strictly in order, so a
// classification sees every write accepted before it.
// The front decodes each transfer into a four-entry command queue; the back
// compares the queue head against all table entries at once and loads the
// result register. An input transfer writes the queue, the result register
// is loaded from the queue head, and the result transfer is taken from the
// result register. One item per cycle is sustained while the receiver keeps
// taking results.
// When out_stall is held, the result register holds its transfer, the back
// stops on the next classification, and in_stall rises once the queue fills.
// The APB register colors_in_use sets how many entries, from entry zero, are searched;
// the user must write it only while the block is idle; the block does not enforce this.
// Synchronous reset clears the queue, the result valid and colors_in_use to
// zero; the table holds unknown contents until each entry is written.
`default_nettype none

module hue_box_color_classifier (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire hbcc_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output hbcc_pkg::out_item_t      out_data,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic [3:0]        colors_r, colors_nxt;
  logic              cfg_wr;
  logic              push;
  logic              pop;
  hbcc_pkg::cmd_t    push_cmd;
  hbcc_pkg::cmd_t    head_cmd;
  hbcc_pkg::q_stat_t stat;

  always_comb begin
    pready     = 1'b1;
    cfg_wr     = psel && penable && pwrite && (paddr[2] == hbcc_pkg::RegColorsInUse);
    colors_nxt = cfg_wr ? pwdata[3:0] : colors_r;
    prdata     = (paddr[2] == hbcc_pkg::RegColorsInUse) ? {28'd0, colors_r} : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colors_r <= hbcc_pkg::ColorsInUseRst;
    end else begin
      colors_r <= colors_nxt;
    end
  end

  hbcc_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (stat.full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  hbcc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .stat     (stat)
  );

  hbcc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .colors_in_use (colors_r),
    .head_cmd      (head_cmd),
    .stat          (stat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

  // The back never takes a command from an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("command taken from an empty queue");

  // No result is presented right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // The search count changes only through an APB write.
  a_cfg_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_wr |=> $stable(colors_r))
    else $error("colors_in_use changed without a write");

endmodule

`default_nettype wire
